// ===== hdl/met_pkg.sv =====
// shared types, constants and helpers of the mandelbrot escape-time block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

	localparam int COORD_W   = 32;  // signed coordinate word
	localparam int STEP_W    = 31;  // unsigned step per pixel
	localparam int POS_W     = 11;  // column and row width
	localparam int COUNT_W   = 8;   // iteration count and limit
	localparam int INDEX_W   = 22;  // linear pixel index
	localparam int FRAC_BITS = 28;  // fraction bits of the coordinate format
	localparam int WIDE_W    = 64;  // exact product width
	localparam int PROD_W    = STEP_W + POS_W;

	localparam int IMAGE_WIDTH = 2048;

	localparam int ESCAPE_RADIUS_SQ = 4;
	localparam logic [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 3);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

	// register reset values
	localparam logic signed [COORD_W-1:0] ORIGIN_RST = -32'sd268435456;
	localparam logic [STEP_W-1:0]         STEP_RST   = 31'd262144;
	localparam logic [COUNT_W-1:0]        LIMIT_RST  = 8'd255;

	// one pixel ready for iteration
	typedef struct packed {
		logic signed [COORD_W-1:0] cr;
		logic signed [COORD_W-1:0] ci;
		logic [INDEX_W-1:0]        idx;
	} met_job_t;

	// clamp a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[WIDE_W-1]}}) begin
			r = v[COORD_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/met_front.sv =====
// front end: takes pixel items, forms the point c and the linear index
// depends on met_pkg; feeds met_queue
`timescale 1ns / 1ps
`default_nettype none

module met_front import met_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [POS_W-1:0]          column,
	input  wire logic [POS_W-1:0]          row,
	input  wire logic signed [COORD_W-1:0] x_origin,
	input  wire logic signed [COORD_W-1:0] y_origin,
	input  wire logic [STEP_W-1:0]         x_step,
	input  wire logic [STEP_W-1:0]         y_step,
	input  wire logic [QLVL_W-1:0]         q_level,
	output logic                           push,
	output met_job_t                       push_job
);

	logic               v_s1;
	logic [PROD_W-1:0]  pr_s1;
	logic [PROD_W-1:0]  pi_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               v_s2;
	met_job_t           job_s2;
	logic               take;
	logic [QLVL_W-1:0]  occupancy;

	// queue entries plus items still in the two front stages
	assign occupancy = q_level + QLVL_W'(v_s1) + QLVL_W'(v_s2);
	assign busy      = occupancy >= QLVL_W'(QUEUE_DEPTH);
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pr_s1  <= PROD_W'(row) * PROD_W'(y_step);
			pi_s1  <= PROD_W'(column) * PROD_W'(x_step);
			idx_s1 <= INDEX_W'(INDEX_W'(row) * INDEX_W'(IMAGE_WIDTH)) + INDEX_W'(column);
		end
		if (v_s1) begin
			job_s2.cr  <= sat_coord(WIDE_W'(y_origin) + $signed(WIDE_W'(pr_s1)));
			job_s2.ci  <= sat_coord(WIDE_W'(x_origin) + $signed(WIDE_W'(pi_s1)));
			job_s2.idx <= idx_s1;
		end
	end

	assign push     = v_s2;
	assign push_job = job_s2;

endmodule

`default_nettype wire

// ===== hdl/met_queue.sv =====
// short job queue between the front end and the iteration core
// depends on met_pkg
`timescale 1ns / 1ps
`default_nettype none

module met_queue import met_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire met_job_t   push_job,
	input  wire logic       pop,
	output logic            pop_valid,
	output met_job_t        pop_job,
	output logic [QLVL_W-1:0] level
);

	met_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_pop;

	assign do_pop    = pop && (level_q != '0);
	assign pop_valid = level_q != '0;
	assign pop_job   = slot_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/met_core.sv =====
// iteration core: runs z = z*z + c for one job at a time
// depends on met_pkg; takes jobs from met_queue
`timescale 1ns / 1ps
`default_nettype none

module met_core import met_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire met_job_t           job,
	output logic                    job_pop,
	input  wire logic [COUNT_W-1:0] iteration_limit,
	output logic                    done,
	output logic [COUNT_W-1:0]      escape_count,
	output logic [INDEX_W-1:0]      pixel_index
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                state_q;
	logic signed [COORD_W-1:0] cr_q;
	logic signed [COORD_W-1:0] ci_q;
	logic [INDEX_W-1:0]        idx_q;
	logic signed [COORD_W-1:0] zr_q;
	logic signed [COORD_W-1:0] zi_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [WIDE_W-1:0]  rr_q;
	logic signed [WIDE_W-1:0]  ii_q;
	logic signed [WIDE_W-1:0]  ri_q;
	logic                      done_q;
	logic [COUNT_W-1:0]        res_count_q;
	logic [INDEX_W-1:0]        res_idx_q;

	logic [WIDE_W-1:0]        mag;
	logic                     escaped;
	logic signed [WIDE_W-1:0] diff;
	logic signed [WIDE_W-1:0] nr_w;
	logic signed [WIDE_W-1:0] ni_w;
	logic                     at_limit;

	assign mag      = $unsigned(rr_q) + $unsigned(ii_q);
	assign escaped  = mag >= ESC_LIMIT;
	assign diff     = rr_q - ii_q;
	assign nr_w     = (diff >>> FRAC_BITS) + WIDE_W'(cr_q);
	assign ni_w     = (ri_q >>> (FRAC_BITS - 1)) + WIDE_W'(ci_q);
	assign at_limit = count_q >= iteration_limit;
	assign job_pop  = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (at_limit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (escaped) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cr_q    <= job.cr;
				ci_q    <= job.ci;
				idx_q   <= job.idx;
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			ST_MUL: begin
				rr_q        <= WIDE_W'(zr_q) * WIDE_W'(zr_q);
				ii_q        <= WIDE_W'(zi_q) * WIDE_W'(zi_q);
				ri_q        <= WIDE_W'(zr_q) * WIDE_W'(zi_q);
				res_count_q <= count_q;
				res_idx_q   <= idx_q;
			end
			ST_UPD: begin
				if (!escaped) begin
					zr_q    <= sat_coord(nr_w);
					zi_q    <= sat_coord(ni_w);
					count_q <= count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign escape_count = res_count_q;
	assign pixel_index  = res_idx_q;

endmodule

`default_nettype wire

// ===== hdl/mandelbrot_escape_time.sv =====
// top level of the mandelbrot escape-time block: configuration registers
// and the front end, job queue and iteration core; depends on met_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: drive column and row with start high; the item is taken
//   at a rising edge where start is high and busy is low
//   result channel: done is high for one cycle with escape_count and
//   pixel_index; the receiver must take it then, there is no hold-off
//   configuration: cfg_write, cfg_index, cfg_data write one register per
//   edge (0 x_origin, 1 y_origin, 2 x_step, 3 y_step, 4 iteration_limit);
//   other indexes are ignored; write only while no item is outstanding
// operation
//   the front end registers the products and the index, then forms c with
//   saturation, and places the job in a four-entry queue; busy rises once
//   four items sit in the front stages and queue together, so at most four
//   wait ahead of the core; the core loads one job while idle and runs each
//   iteration as a multiply state (which also tests the limit) followed by
//   an escape test and update state, and it returns to idle before it takes
//   the next job, so the iteration loop sets the rate
// reset
//   arst_n clears the queue, pipeline valids and core state, and loads the
//   registers with -1.0 origins, 2/2048 steps and a limit of 255

module mandelbrot_escape_time import met_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [POS_W-1:0]     column,
	input  wire logic [POS_W-1:0]     row,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	output logic                      done,
	output logic [COUNT_W-1:0]        escape_count,
	output logic [INDEX_W-1:0]        pixel_index
);

	// configuration registers
	logic signed [COORD_W-1:0] x_origin_q;
	logic signed [COORD_W-1:0] y_origin_q;
	logic [STEP_W-1:0]         x_step_q;
	logic [STEP_W-1:0]         y_step_q;
	logic [COUNT_W-1:0]        limit_q;

	// front end to queue
	logic              push;
	met_job_t          push_job;
	logic [QLVL_W-1:0] q_level;

	// queue to core
	logic     pop;
	logic     pop_valid;
	met_job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= ORIGIN_RST;
			y_origin_q <= ORIGIN_RST;
			x_step_q   <= STEP_RST;
			y_step_q   <= STEP_RST;
			limit_q    <= LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_X_ORIGIN:   x_origin_q <= $signed(cfg_data);
				REG_Y_ORIGIN:   y_origin_q <= $signed(cfg_data);
				REG_X_STEP:     x_step_q   <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:     y_step_q   <= cfg_data[STEP_W-1:0];
				REG_ITER_LIMIT: limit_q    <= cfg_data[COUNT_W-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// front end: accept, point and index
	met_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.column   (column),
		.row      (row),
		.x_origin (x_origin_q),
		.y_origin (y_origin_q),
		.x_step   (x_step_q),
		.y_step   (y_step_q),
		.q_level  (q_level),
		.push     (push),
		.push_job (push_job)
	);

	// decoupling queue
	met_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.level     (q_level)
	);

	// back end: escape-time iteration
	met_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (pop_valid),
		.job             (pop_job),
		.job_pop         (pop),
		.iteration_limit (limit_q),
		.done            (done),
		.escape_count    (escape_count),
		.pixel_index     (pixel_index)
	);

endmodule

`default_nettype wire

// ===== hdl/met_checker.sv =====
// port-level checks of the mandelbrot escape-time block, bound to the top
// depends on met_pkg and mandelbrot_escape_time
`timescale 1ns / 1ps
`default_nettype none

module met_checker import met_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 cfg_write,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [COORD_W-1:0]   cfg_data,
	input wire logic                 done,
	input wire logic [COUNT_W-1:0]   escape_count
);

	logic [3:0]         pending_q;
	logic [COUNT_W-1:0] limit_m_q;
	logic               accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			limit_m_q <= LIMIT_RST;
		end else begin
			pending_q <= pending_q + 4'(accept) - 4'(done);
			if (cfg_write && cfg_index == REG_ITER_LIMIT) begin
				limit_m_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	// every result belongs to an item taken earlier
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pending_q != '0)
		else $error("result without an outstanding item");

	// the core reloads between jobs, so results never come back to back
	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	// the count never passes the programmed limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> escape_count <= limit_m_q)
		else $error("escape count above iteration limit");

	// no more items in flight than front stages, queue and core can hold
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(QUEUE_DEPTH + 3))
		else $error("too many outstanding items");

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the mandelbrot escape-time block
// holds its own fixed-point escape-time predictor; depends on met_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
	import met_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;  // quiet cycles before giving up
	localparam int SETTLE_CYCLES   = 8;     // extra wait after the last result
	localparam int DRAIN_CYCLES    = 16;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int MAX_REPORTS     = 40;

	localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	// |z|^2 of the product scale, two fraction fields deep
	localparam bit [WIDE_W-1:0] ESCAPE_SQ = WIDE_W'(ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

	// views of the plane in Q4.28
	localparam logic [COORD_W-1:0] Q_MINUS_TWO  = 32'hE000_0000;
	localparam logic [COORD_W-1:0] Q_MINUS_1P25 = 32'hEC00_0000;
	localparam logic [COORD_W-1:0] Q_QUARTER    = 32'h0400_0000;
	localparam logic [COORD_W-1:0] Q_SPAN       = 32'h2800_0000;  // 2.5
	localparam logic [COORD_W-1:0] VIEW_STEP    = 32'd327680;     // 2.5 / 2048
	localparam logic signed [COORD_W-1:0] SEAHORSE_RE = -32'sd204010947;  // -0.76
	localparam logic signed [COORD_W-1:0] SEAHORSE_IM = 32'sd24159191;    // 0.09
	localparam logic [COORD_W-1:0] ZOOM_STEP    = 32'd2621;       // 0.02 / 2048

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [INDEX_W-1:0] index;
	} pixel_outcome_t;

	class pixel_scoreboard;
		logic signed [COORD_W-1:0] x_origin, y_origin;
		logic [STEP_W-1:0]         x_step, y_step;
		logic [COUNT_W-1:0]        iter_limit;
		pixel_outcome_t            expected_pixels[$];
		int                        failures, checked, inside_hits;

		function new();
			x_origin    = ORIGIN_RST;
			y_origin    = ORIGIN_RST;
			x_step      = STEP_RST;
			y_step      = STEP_RST;
			iter_limit  = LIMIT_RST;
			failures    = 0;
			checked     = 0;
			inside_hits = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
			case (idx)
				REG_X_ORIGIN:   x_origin = data;
				REG_Y_ORIGIN:   y_origin = data;
				REG_X_STEP:     x_step = data[STEP_W-1:0];
				REG_Y_STEP:     y_step = data[STEP_W-1:0];
				REG_ITER_LIMIT: iter_limit = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp_coord(longint v);
			if (v > COORD_MAX) return COORD_MAX;
			if (v < COORD_MIN) return COORD_MIN;
			return v;
		endfunction

		// z = z*z + c from zero until |z|^2 reaches 4 or the limit runs out
		function logic [COUNT_W-1:0] escape_count_of(logic [POS_W-1:0] col, logic [POS_W-1:0] rw);
			longint          cr, ci, zr, zi, rr, ii;
			bit [WIDE_W-1:0] mag;
			int              n;
			cr = clamp_coord(longint'(y_origin) + longint'(rw) * longint'(y_step));
			ci = clamp_coord(longint'(x_origin) + longint'(col) * longint'(x_step));
			zr = 0;
			zi = 0;
			n  = 0;
			while (n < iter_limit) begin
				rr  = zr * zr;
				ii  = zi * zi;
				mag = rr + ii;
				if (mag >= ESCAPE_SQ) break;
				zi = clamp_coord(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
				zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + cr);
				n++;
			end
			return n[COUNT_W-1:0];
		endfunction

		function void note_item(logic [POS_W-1:0] col, logic [POS_W-1:0] rw);
			pixel_outcome_t want;
			want.count = escape_count_of(col, rw);
			want.index = INDEX_W'(longint'(rw) * IMAGE_WIDTH + longint'(col));
			if (iter_limit != 0 && want.count == iter_limit) inside_hits++;
			expected_pixels.push_back(want);
		endfunction

		function void report(string what, longint want, longint got);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_result(logic [COUNT_W-1:0] cnt, logic [INDEX_W-1:0] idx);
			pixel_outcome_t want;
			if (expected_pixels.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: stray result: expected none, actual count %0d index %0d",
						$time, cnt, idx);
				return;
			end
			want = expected_pixels.pop_front();
			checked++;
			if (cnt !== want.count)
				report($sformatf("escape_count of pixel %0d", want.index), want.count, cnt);
			if (idx !== want.index)
				report("pixel_index", want.index, idx);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic [POS_W-1:0]     column    = '0;
	logic [POS_W-1:0]     row       = '0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;
	logic                 busy;
	logic                 done;
	logic [COUNT_W-1:0]   escape_count;
	logic [INDEX_W-1:0]   pixel_index;

	pixel_scoreboard board = new();
	int items_taken = 0;
	int settings    = 0;
	int quiet_cycles = 0;

	mandelbrot_escape_time dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.column       (column),
		.row          (row),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.escape_count (escape_count),
		.pixel_index  (pixel_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: sample both channels on the edge that accepts them
	// watchdog: any accepted item or result restarts the quiet count
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			board.note_item(column, row);
			items_taken++;
		end
		if (arst_n && done)
			board.check_result(escape_count, pixel_index);
		if (arst_n && ((start && !busy) || done))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: nothing accepted for %0d cycles", $time, quiet_cycles);
			$display("tb_top: errors");
			$finish;
		end
	end

	// mostly back-to-back or short gaps, now and then a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// hold one pixel on the inputs until the block takes it; start stays
	// high into the next item when there is no gap
	task automatic present_pixel(input logic [POS_W-1:0] col, input logic [POS_W-1:0] rw,
		input int gap);
		start  <= 1'b1;
		column <= col;
		row    <= rw;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait out every outstanding pixel
	task automatic settle(input int extra);
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// load all five registers back to back, then poke one unmapped index,
	// which the block has to ignore; upper data bits carry noise to check masking
	task automatic program_view(input logic [COORD_W-1:0] xo, input logic [COORD_W-1:0] yo,
		input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
		input logic [COUNT_W-1:0] lim);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [COORD_W-1:0]   val [6];
		idx = '{REG_X_ORIGIN, REG_Y_ORIGIN, REG_X_STEP, REG_Y_STEP, REG_ITER_LIMIT,
			CFG_IDX_W'($urandom_range(REG_ITER_LIMIT + 1, (1 << CFG_IDX_W) - 1))};
		val = '{xo, yo, xs, ys, {(COORD_W - COUNT_W)'($urandom), lim}, $urandom};
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			board.write_reg(idx[i], val[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		settings++;
	endtask

	initial begin
		bit steady;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset view: corners, c = 0 (never escapes), alternating bit patterns
		present_pixel(11'd0, 11'd0, pick_gap());
		present_pixel(11'd2047, 11'd2047, pick_gap());
		present_pixel(11'd1024, 11'd1024, pick_gap());
		present_pixel(11'd0, 11'd2047, pick_gap());
		present_pixel(11'd2047, 11'd0, pick_gap());
		present_pixel(11'h555, 11'h2AA, pick_gap());
		present_pixel(11'h2AA, 11'h555, pick_gap());
		present_pixel(11'd1024, 11'd256, pick_gap());

		// limit of zero: no iteration at all
		settle(SETTLE_CYCLES);
		program_view('0, Q_MINUS_TWO, '0, '0, 8'd0);
		present_pixel(11'd5, 11'd7, pick_gap());
		present_pixel(11'd2047, 11'd2047, pick_gap());

		// limit of one
		settle(SETTLE_CYCLES);
		program_view('0, Q_MINUS_TWO, '0, '0, 8'd1);
		present_pixel(11'd0, 11'd0, pick_gap());
		present_pixel(11'd2047, 11'd2047, pick_gap());

		// c = -2 lands exactly on |z|^2 = 4 after one step
		settle(SETTLE_CYCLES);
		program_view('0, Q_MINUS_TWO, '0, '0, LIMIT_RST);
		present_pixel(11'd0, 11'd0, pick_gap());
		present_pixel(11'd2047, 11'd2047, pick_gap());

		// extreme origins with all-ones steps: c starts at the ends of the range and saturates upward
		settle(SETTLE_CYCLES);
		program_view(32'h7FFF_FFFF, 32'h8000_0000, '1, '1, LIMIT_RST);
		present_pixel(11'd0, 11'd0, pick_gap());
		present_pixel(11'd2047, 11'd2047, pick_gap());
		present_pixel(11'd2047, 11'd0, pick_gap());
		present_pixel(11'd0, 11'd2047, pick_gap());

		// cusp at 0.25 and slow escapes just past it
		settle(SETTLE_CYCLES);
		program_view('0, Q_QUARTER, '0, 32'h0010_0000, LIMIT_RST);
		present_pixel(11'd0, 11'd0, pick_gap());
		present_pixel(11'd0, 11'd3, pick_gap());
		present_pixel(11'd0, 11'd5, pick_gap());

		// random pixels over a rotating set of views and limits
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle(SETTLE_CYCLES);
			case (p % 5)
				0: program_view(Q_MINUS_1P25, Q_MINUS_TWO, VIEW_STEP, VIEW_STEP, LIMIT_RST);
				1: program_view(SEAHORSE_IM, SEAHORSE_RE, ZOOM_STEP, ZOOM_STEP,
					COUNT_W'($urandom_range(64, 255)));
				2: program_view(Q_MINUS_1P25, Q_MINUS_TWO, VIEW_STEP, VIEW_STEP,
					COUNT_W'($urandom_range(1, 16)));
				3: program_view($urandom, $urandom, $urandom >> $urandom_range(0, 31),
					$urandom >> $urandom_range(0, 31), COUNT_W'($urandom_range(0, 255)));
				default: program_view(Q_MINUS_1P25 + $urandom_range(0, Q_SPAN),
					Q_MINUS_TWO + $urandom_range(0, Q_SPAN), $urandom_range(1, 400000),
					$urandom_range(1, 400000), COUNT_W'($urandom_range(1, 255)));
			endcase
			// some phases run with no gaps at all
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				present_pixel(POS_W'($urandom), POS_W'($urandom), steady ? 0 : pick_gap());
		end

		settle(DRAIN_CYCLES);
		$display("summary: %0d pixels over %0d register settings, %0d results checked",
			items_taken, settings, board.checked);
		$display("summary: %0d pixels ran to the iteration limit, %0d failures",
			board.inside_hits, board.failures);
		if (board.failures == 0 && board.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
